FILE: design/gzhp_pkg.sv
// Types and constants shared by the gzip header parser modules.
// No dependencies.
package gzhp_pkg;

  localparam logic [1:0] KIND_ERROR = 2'd0;
  localparam logic [1:0] KIND_TIME  = 2'd1;
  localparam logic [1:0] KIND_NAME  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [7:0] MAGIC_ID1 = 8'h1F;
  localparam logic [7:0] MAGIC_ID2 = 8'h8B;

  localparam int unsigned FLAG_EXTRA_BIT = 2;
  localparam int unsigned FLAG_NAME_BIT  = 3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } gzhp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        time_found;
  } gzhp_out_t;

  // Result of one parse step: whether it emits, and what.
  typedef struct packed {
    logic      valid;
    gzhp_out_t item;
  } gzhp_res_t;

endpackage

FILE: design/gzhp_fsm.sv
// Header parse state machine: one byte per step, zero or one result.
// Depends on gzhp_pkg.
module gzhp_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  gzhp_pkg::gzhp_in_t  in_item,
  output gzhp_pkg::gzhp_res_t res
);

  typedef enum logic [3:0] {
    PH_ID1, PH_ID2, PH_METHOD, PH_FLAGS, PH_MTIME,
    PH_XFL, PH_OS, PH_XLEN, PH_EXTRA, PH_NAME, PH_IDLE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        extra_r, extra_nxt;
  logic        name_r, name_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] skip_r, skip_nxt;

  logic [7:0]  b;
  phase_t      ph;

  always_comb begin
    b         = in_item.byte_in;
    ph        = in_item.restart ? PH_ID1 : phase_r;
    phase_nxt = ph;
    idx_nxt   = idx_r;
    extra_nxt = extra_r;
    name_nxt  = name_r;
    acc_nxt   = acc_r;
    skip_nxt  = skip_r;
    res       = '0;

    case (ph)
      PH_ID1: begin
        extra_nxt = 1'b0;
        name_nxt  = 1'b0;
        acc_nxt   = '0;
        skip_nxt  = '0;
        idx_nxt   = {1'b0, b == gzhp_pkg::MAGIC_ID1};
        phase_nxt = PH_ID2;
      end
      PH_ID2: begin
        idx_nxt = 2'd0;
        if (idx_r[0] && b == gzhp_pkg::MAGIC_ID2) begin
          phase_nxt = PH_METHOD;
        end else begin
          phase_nxt      = PH_IDLE;
          res.valid      = 1'b1;
          res.item.kind  = gzhp_pkg::KIND_ERROR;
        end
      end
      PH_METHOD: phase_nxt = PH_FLAGS;
      PH_FLAGS: begin
        extra_nxt = b[gzhp_pkg::FLAG_EXTRA_BIT];
        name_nxt  = b[gzhp_pkg::FLAG_NAME_BIT];
        idx_nxt   = 2'd0;
        acc_nxt   = '0;
        phase_nxt = PH_MTIME;
      end
      PH_MTIME: begin
        // little-endian: byte idx lands in lane idx
        case (idx_r)
          2'd0:    acc_nxt = acc_r | {24'd0, b};
          2'd1:    acc_nxt = acc_r | {16'd0, b, 8'd0};
          2'd2:    acc_nxt = acc_r | {8'd0, b, 16'd0};
          default: acc_nxt = acc_r | {b, 24'd0};
        endcase
        if (idx_r == 2'd3) begin
          idx_nxt                = 2'd0;
          phase_nxt              = PH_XFL;
          res.valid              = 1'b1;
          res.item.kind          = gzhp_pkg::KIND_TIME;
          res.item.value         = acc_nxt;
          res.item.time_found    = acc_nxt != 32'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      PH_XFL: phase_nxt = PH_OS;
      PH_OS: begin
        if (extra_r) begin
          idx_nxt   = 2'd0;
          phase_nxt = PH_XLEN;
        end else if (name_r) begin
          phase_nxt = PH_NAME;
        end else begin
          phase_nxt     = PH_IDLE;
          res.valid     = 1'b1;
          res.item.kind = gzhp_pkg::KIND_DONE;
        end
      end
      PH_XLEN: begin
        if (!idx_r[0]) begin
          skip_nxt = {8'd0, b};
          idx_nxt  = 2'd1;
        end else begin
          skip_nxt = {b, skip_r[7:0]};
          idx_nxt  = 2'd0;
          if (skip_nxt != 16'd0) begin
            phase_nxt = PH_EXTRA;
          end else if (name_r) begin
            phase_nxt = PH_NAME;
          end else begin
            phase_nxt     = PH_IDLE;
            res.valid     = 1'b1;
            res.item.kind = gzhp_pkg::KIND_DONE;
          end
        end
      end
      PH_EXTRA: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == 16'd0) begin
          if (name_r) begin
            phase_nxt = PH_NAME;
          end else begin
            phase_nxt     = PH_IDLE;
            res.valid     = 1'b1;
            res.item.kind = gzhp_pkg::KIND_DONE;
          end
        end
      end
      PH_NAME: begin
        res.valid = 1'b1;
        if (b == 8'd0) begin
          phase_nxt     = PH_IDLE;
          res.item.kind = gzhp_pkg::KIND_DONE;
        end else begin
          res.item.kind  = gzhp_pkg::KIND_NAME;
          res.item.value = {24'd0, b};
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID1;
      idx_r   <= 2'd0;
      extra_r <= 1'b0;
      name_r  <= 1'b0;
      acc_r   <= '0;
      skip_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      extra_r <= extra_nxt;
      name_r  <= name_nxt;
      acc_r   <= acc_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

FILE: design/gzip_header_parser.sv
// gzip member header parser top level: input register, parse step, result register.
// Depends on gzhp_pkg and gzhp_fsm.
//
//   channel | ports                           | payload
//   --------+---------------------------------+---------------------------
//   input   | in_valid, in_stall, in_data     | gzhp_in_t  (byte, restart)
//   result  | out_valid, out_stall, out_data  | gzhp_out_t (kind, value, found)
//
// One byte per cycle sustained while results are not stalled; a result passes the input
// register and the result register; the combinational parse step sets the rate.
// Synchronous active-low reset puts the parser at the first magic byte.
// A stalled result holds the parse step; in_stall rises as soon as a byte is held
// in the input register, so at most one byte waits there.
module gzip_header_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gzhp_pkg::gzhp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gzhp_pkg::gzhp_out_t out_data
);

  logic                in_valid_r;
  gzhp_pkg::gzhp_in_t  in_data_r;
  logic                out_valid_r;
  gzhp_pkg::gzhp_out_t out_data_r;

  logic                advance;
  logic                accept;
  gzhp_pkg::gzhp_res_t res;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gzhp_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .in_item (in_data_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance && res.valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
    if (advance && res.valid) begin
      out_data_r <= res.item;
    end
  end

  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with empty input register");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid |=> out_valid_r)
    else $error("parse result not registered");

  a_found_matches_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind == gzhp_pkg::KIND_TIME
      |-> out_data_r.time_found == (out_data_r.value != 32'd0))
    else $error("time_found disagrees with modification time");

  a_found_only_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind != gzhp_pkg::KIND_TIME |-> !out_data_r.time_found)
    else $error("time_found set on non-time transaction");

endmodule
